// File: sv/rbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the bounding sphere block.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int SQ_W       = 52;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int DVD_W      = 52;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

    typedef logic [2:0][COORD_W-1:0] point_t;

endpackage

// File: sv/ritter_bounding_sphere.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ritter_bounding_sphere
// Streams a point set into a store, tracks extremes, then builds the sphere.
// ----------------------------------------------------------------------------
// channel  dir  tdata                              tuser     tlast
// s_       in   x, y, z (24 each)                  -         last point
// m_       out  centre x, y, z (24 each), radius   overflow  -
//
// Points load at one beat per cycle. After the last beat: span search over the
// three extreme pairs, a square root for the first radius, then per stored point
// a distance check, plus a square root and three divides when it grows the sphere.
// Reset clears counters and handshakes; the store needs no clearing.
// s_tready is low while a sphere is built; a pending result does not stall
// loading of the next set, only the hand-over of its result.
// ----------------------------------------------------------------------------
module ritter_bounding_sphere (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // point_x, point_y, point_z
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // center_x, center_y, center_z, sphere_radius
    output logic         m_tuser    // overflow
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SPAN  = 4'd1;
    localparam logic [3:0] S_MID   = 4'd2;
    localparam logic [3:0] S_RAD   = 4'd3;
    localparam logic [3:0] S_RSQRT = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PDIST = 4'd6;
    localparam logic [3:0] S_PSQRT = 4'd7;
    localparam logic [3:0] S_PSQR  = 4'd8;
    localparam logic [3:0] S_PSQR2 = 4'd9;
    localparam logic [3:0] S_PMUL  = 4'd10;
    localparam logic [3:0] S_PDIV  = 4'd11;
    localparam logic [3:0] S_PDW   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    localparam int CW = rbs_pkg::COORD_W;
    localparam int RW = rbs_pkg::ROOT_W;
    localparam int QW = rbs_pkg::SQ_W;

    logic [3:0]              state_reg;
    logic [rbs_pkg::CNT_W-1:0] count_reg;
    logic [rbs_pkg::CNT_W-1:0] i_reg;
    logic                    dropped_reg;
    rbs_pkg::point_t         ext_reg [6];
    rbs_pkg::point_t         center_reg;
    logic [RW-1:0]           radius_reg;
    logic [RW-1:0]           d_reg;
    logic [QW-1:0]           sqr_reg;
    logic [QW-1:0]           acc_reg;
    logic [QW-1:0]           span_reg;
    logic [1:0]              k_reg;
    logic [1:0]              j_reg;
    logic [1:0]              best_reg;
    logic signed [53:0]      prod_reg;
    logic                    neg_reg;

    logic                    m_tvalid_reg;
    rbs_pkg::point_t         out_center_reg;
    logic [RW-2:0]           out_radius_reg;
    logic                    out_ovf_reg;

    rbs_pkg::point_t         in_pt;
    rbs_pkg::point_t         rd_pt;
    logic                    s_hs;
    logic                    wr_en;
    logic                    rd_en;
    logic signed [26:0]      mul_a;
    logic signed [26:0]      mul_b;
    logic signed [CW:0]      dif;
    logic [QW-1:0]           sq_total;
    logic                    sqrt_start;
    logic [QW-1:0]           sqrt_in;
    logic [RW-1:0]           sqrt_root;
    logic                    sqrt_done;
    logic                    div_start;
    logic [rbs_pkg::DVD_W-1:0] div_in;
    logic [rbs_pkg::DVD_W-1:0] div_q;
    logic                    div_done;
    logic signed [53:0]      prod_abs;
    logic [RW:0]             r_sum;
    logic [RW-1:0]           d_eff;
    logic signed [CW+1:0]    q_s;
    logic signed [CW+1:0]    c_new;
    logic signed [CW:0]      mid_sum [3];
    logic signed [CW:0]      mid_half [3];
    logic                    last_pt;

    assign in_pt    = s_tdata;
    assign s_tready = (state_reg == S_LOAD);
    assign s_hs     = s_tvalid && s_tready;
    assign wr_en    = s_hs && (count_reg < rbs_pkg::CNT_W'(rbs_pkg::MAX_POINTS));
    assign rd_en    = (state_reg == S_PRD);

    rbs_point_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[rbs_pkg::ADDR_W-1:0]),
        .wr_data (in_pt),
        .rd_en   (rd_en),
        .rd_addr (i_reg[rbs_pkg::ADDR_W-1:0]),
        .rd_data (rd_pt)
    );

    rbs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    rbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_in),
        .divisor  (d_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    // operand selection for the shared multiplier
    always_comb begin
        dif = '0;
        unique case (state_reg)
            S_SPAN: dif = $signed({ext_reg[3 + j_reg][k_reg][CW-1], ext_reg[3 + j_reg][k_reg]})
                        - $signed({ext_reg[j_reg][k_reg][CW-1], ext_reg[j_reg][k_reg]});
            S_RAD: dif = $signed({ext_reg[3 + best_reg][k_reg][CW-1],
                                  ext_reg[3 + best_reg][k_reg]})
                       - $signed({center_reg[k_reg][CW-1], center_reg[k_reg]});
            S_PDIST: dif = $signed({rd_pt[k_reg][CW-1], rd_pt[k_reg]})
                         - $signed({center_reg[k_reg][CW-1], center_reg[k_reg]});
            S_PMUL: dif = $signed({center_reg[k_reg][CW-1], center_reg[k_reg]})
                        - $signed({rd_pt[k_reg][CW-1], rd_pt[k_reg]});
            default: dif = '0;
        endcase
        mul_a = 27'(dif);
        mul_b = 27'(dif);
        if (state_reg == S_PMUL) begin
            mul_b = $signed({1'b0, radius_reg});
        end else if (state_reg == S_PSQR) begin
            mul_a = $signed({1'b0, radius_reg});
            mul_b = $signed({1'b0, radius_reg});
        end
    end

    assign sq_total = acc_reg + prod_reg[QW-1:0];
    assign prod_abs = prod_reg[53] ? -prod_reg : prod_reg;
    assign div_in   = prod_abs[rbs_pkg::DVD_W-1:0];
    assign d_eff    = (sqrt_root == '0) ? RW'(1) : sqrt_root;
    assign r_sum    = {1'b0, radius_reg} + {1'b0, d_eff};
    assign q_s      = neg_reg ? -$signed({1'b0, div_q[CW:0]}) : $signed({1'b0, div_q[CW:0]});
    assign c_new    = $signed({{2{rd_pt[k_reg][CW-1]}}, rd_pt[k_reg]}) + q_s;
    assign last_pt  = (i_reg + 1'b1 == count_reg);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mid_sum[k]  = $signed({ext_reg[best_reg][k][CW-1], ext_reg[best_reg][k]})
                        + $signed({ext_reg[3 + best_reg][k][CW-1], ext_reg[3 + best_reg][k]});
            mid_half[k] = (mid_sum[k] + $signed({{CW{1'b0}}, mid_sum[k][CW]})) >>> 1;
        end
    end

    always_comb begin
        sqrt_start = 1'b0;
        sqrt_in    = sq_total;
        if ((state_reg == S_RAD || state_reg == S_PDIST) && k_reg == 2'd3) begin
            sqrt_start = (state_reg == S_RAD) || (sq_total > sqr_reg);
        end
        div_start = (state_reg == S_PDIV);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 54'(mul_a * mul_b);
        if (s_hs && wr_en) begin
            for (int k = 0; k < 3; k++) begin
                if (count_reg == '0) begin
                    ext_reg[k]     <= in_pt;
                    ext_reg[3 + k] <= in_pt;
                end else begin
                    if ($signed(in_pt[k]) < $signed(ext_reg[k][k])) begin
                        ext_reg[k] <= in_pt;
                    end
                    if ($signed(in_pt[k]) > $signed(ext_reg[3 + k][k])) begin
                        ext_reg[3 + k] <= in_pt;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            i_reg        <= '0;
            dropped_reg  <= 1'b0;
            k_reg        <= '0;
            j_reg        <= '0;
            best_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (s_hs) begin
                        if (wr_en) begin
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= S_SPAN;
                            k_reg     <= '0;
                            j_reg     <= '0;
                        end
                    end
                end
                S_SPAN: begin
                    k_reg   <= k_reg + 1'b1;
                    acc_reg <= (k_reg == 2'd0) ? '0 : sq_total;
                    if (k_reg == 2'd3) begin
                        if (j_reg == 2'd0 || sq_total > span_reg) begin
                            span_reg <= sq_total;
                            best_reg <= j_reg;
                        end
                        j_reg <= j_reg + 1'b1;
                        if (j_reg == 2'd2) begin
                            state_reg <= S_MID;
                        end
                    end
                end
                S_MID: begin
                    for (int k = 0; k < 3; k++) begin
                        center_reg[k] <= mid_half[k][CW-1:0];
                    end
                    k_reg     <= '0;
                    state_reg <= S_RAD;
                end
                S_RAD: begin
                    k_reg   <= k_reg + 1'b1;
                    acc_reg <= (k_reg == 2'd0) ? '0 : sq_total;
                    if (k_reg == 2'd3) begin
                        sqr_reg   <= sq_total;
                        state_reg <= S_RSQRT;
                    end
                end
                S_RSQRT: begin
                    if (sqrt_done) begin
                        radius_reg <= sqrt_root;
                        i_reg      <= '0;
                        state_reg  <= S_PRD;
                    end
                end
                S_PRD: begin
                    k_reg     <= '0;
                    state_reg <= S_PDIST;
                end
                S_PDIST: begin
                    k_reg   <= k_reg + 1'b1;
                    acc_reg <= (k_reg == 2'd0) ? '0 : sq_total;
                    if (k_reg == 2'd3) begin
                        if (sq_total > sqr_reg) begin
                            state_reg <= S_PSQRT;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= last_pt ? S_DONE : S_PRD;
                        end
                    end
                end
                S_PSQRT: begin
                    if (sqrt_done) begin
                        d_reg      <= d_eff;
                        radius_reg <= r_sum[RW:1];
                        state_reg  <= S_PSQR;
                    end
                end
                S_PSQR: begin
                    state_reg <= S_PSQR2;
                end
                S_PSQR2: begin
                    sqr_reg   <= prod_reg[QW-1:0];
                    k_reg     <= '0;
                    state_reg <= S_PMUL;
                end
                S_PMUL: begin
                    state_reg <= S_PDIV;
                end
                S_PDIV: begin
                    neg_reg   <= prod_reg[53];
                    state_reg <= S_PDW;
                end
                S_PDW: begin
                    if (div_done) begin
                        center_reg[k_reg] <= c_new[CW-1:0];
                        k_reg             <= k_reg + 1'b1;
                        if (k_reg == 2'd2) begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= last_pt ? S_DONE : S_PRD;
                        end else begin
                            state_reg <= S_PMUL;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg) begin
                        m_tvalid_reg   <= 1'b1;
                        out_center_reg <= center_reg;
                        out_radius_reg <= radius_reg[RW-2:0];
                        out_ovf_reg    <= dropped_reg;
                        count_reg      <= '0;
                        dropped_reg    <= 1'b0;
                        state_reg      <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_radius_reg, out_center_reg};
    assign m_tuser  = out_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rbs_pkg::CNT_W'(rbs_pkg::MAX_POINTS))
        else $error("point count beyond capacity");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PRD |-> i_reg < count_reg)
        else $error("pass reads beyond stored points");

    a_result_clears_set: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !m_tvalid_reg |=> count_reg == '0 && m_tvalid_reg)
        else $error("result hand-over did not restart the set");

    a_sqrt_only_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == S_RSQRT || state_reg == S_PSQRT)
        else $error("square root finished outside a wait state");

endmodule

// File: sv/rbs_point_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_point_ram
// Point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbs_point_ram (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [rbs_pkg::ADDR_W-1:0] wr_addr,
    input  rbs_pkg::point_t            wr_data,
    input  logic                       rd_en,
    input  logic [rbs_pkg::ADDR_W-1:0] rd_addr,
    output rbs_pkg::point_t            rd_data
);

    rbs_pkg::point_t mem [rbs_pkg::MAX_POINTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/rbs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_sqrt
// Floored integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rbs_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rbs_pkg::SQ_W-1:0]   radicand,
    output logic [rbs_pkg::ROOT_W-1:0] root,
    output logic                       done
);

    logic [rbs_pkg::SQ_W-1:0]       rad_reg;
    logic [rbs_pkg::ROOT_W+1:0]     rem_reg;
    logic [rbs_pkg::ROOT_W-1:0]     root_reg;
    logic [rbs_pkg::SQRT_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [rbs_pkg::ROOT_W+1:0]     rem_sh;
    logic [rbs_pkg::ROOT_W+1:0]     trial;

    assign rem_sh = {rem_reg[rbs_pkg::ROOT_W-1:0], rad_reg[rbs_pkg::SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg <= {rad_reg[rbs_pkg::SQ_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[rbs_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[rbs_pkg::ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rbs_pkg::SQRT_CNT_W'(rbs_pkg::ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// File: sv/rbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbs_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rbs_pkg::DVD_W-1:0]  dividend,
    input  logic [rbs_pkg::ROOT_W-1:0] divisor,
    output logic [rbs_pkg::DVD_W-1:0]  quotient,
    output logic                       done
);

    logic [rbs_pkg::DVD_W-1:0]     q_reg;
    logic [rbs_pkg::ROOT_W-1:0]    dsr_reg;
    logic [rbs_pkg::ROOT_W:0]      rem_reg;
    logic [rbs_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [rbs_pkg::ROOT_W:0]      rem_sh;

    assign rem_sh = {rem_reg[rbs_pkg::ROOT_W-1:0], q_reg[rbs_pkg::DVD_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                if (rem_sh >= {1'b0, dsr_reg}) begin
                    rem_reg <= rem_sh - {1'b0, dsr_reg};
                    q_reg   <= {q_reg[rbs_pkg::DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[rbs_pkg::DVD_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rbs_pkg::DIV_CNT_W'(rbs_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// File: tb/sv/ritter_bounding_sphere_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ritter_bounding_sphere_checker
// Watches both channels of the bounding sphere block. It predicts each sphere
// from the accepted point beats and compares every result beat, field by
// field, with the oldest predicted sphere.
// ----------------------------------------------------------------------------
module ritter_bounding_sphere_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,   // point_x, point_y, point_z
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,   // center_x, center_y, center_z, sphere_radius
    input  logic         m_tuser,   // overflow
    output int           errors,
    output int           spheres_due
);

    typedef longint vec_t [3];

    typedef struct {
        logic [rbs_pkg::COORD_W-1:0] cx;
        logic [rbs_pkg::COORD_W-1:0] cy;
        logic [rbs_pkg::COORD_W-1:0] cz;
        logic [24:0]                 radius;
        logic                        overflow;
    } sphere_t;

    sphere_t spheres_q[$];

    vec_t            pts [rbs_pkg::MAX_POINTS];
    vec_t            ext [6];   // min x, y, z, then max x, y, z
    vec_t            ctr;
    int              n_pts;
    longint unsigned rad;
    longint unsigned rad_sq;
    logic            dropped;

    function automatic longint unsigned dist_sq(input vec_t a, input vec_t b);
        longint unsigned s;
        longint          d;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            d = a[k] - b[k];
            s += longint'(d * d);
        end
        return s;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic fit_sphere();
        int              axis;
        longint unsigned span;
        longint unsigned best_span;
        longint unsigned sq;
        longint unsigned d;
        longint          prod;
        axis = 0;
        best_span = dist_sq(ext[3], ext[0]);
        for (int a = 1; a < 3; a++) begin
            span = dist_sq(ext[3+a], ext[a]);
            if (span > best_span) begin
                best_span = span;
                axis = a;
            end
        end
        for (int k = 0; k < 3; k++) ctr[k] = (ext[axis][k] + ext[3+axis][k]) / 2;
        rad_sq = dist_sq(ext[3+axis], ctr);
        rad = floor_root(rad_sq);
        for (int i = 0; i < n_pts; i++) begin
            sq = dist_sq(pts[i], ctr);
            if (sq > rad_sq) begin
                d = floor_root(sq);
                if (d == 0) d = 1;
                rad = (rad + d) / 2;
                rad_sq = rad * rad;
                for (int k = 0; k < 3; k++) begin
                    prod = (ctr[k] - pts[i][k]) * longint'(rad);
                    ctr[k] = pts[i][k] + prod / longint'(d);
                end
            end
        end
    endtask

    task automatic take_point();
        vec_t    p;
        sphere_t e;
        p[0] = longint'($signed(s_tdata[23:0]));
        p[1] = longint'($signed(s_tdata[47:24]));
        p[2] = longint'($signed(s_tdata[71:48]));
        if (n_pts < rbs_pkg::MAX_POINTS) begin
            if (n_pts == 0) begin
                for (int k = 0; k < 6; k++) ext[k] = p;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (p[k] < ext[k][k]) ext[k] = p;
                    if (p[k] > ext[3+k][k]) ext[3+k] = p;
                end
            end
            pts[n_pts] = p;
            n_pts++;
        end else begin
            dropped = 1'b1;
        end
        if (s_tlast) begin
            fit_sphere();
            e.cx = ctr[0][23:0];
            e.cy = ctr[1][23:0];
            e.cz = ctr[2][23:0];
            e.radius = rad[24:0];
            e.overflow = dropped;
            spheres_q = {spheres_q, e};
            n_pts = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic check_sphere();
        sphere_t e;
        if (spheres_q.size() == 0) begin
            $display("%0t: unexpected sphere beat, actual %h / %b", $time, m_tdata, m_tuser);
            errors++;
            return;
        end
        e = spheres_q.pop_front();
        if (m_tdata[23:0] !== e.cx) begin
            $display("%0t: center_x expected %h actual %h", $time, e.cx, m_tdata[23:0]);
            errors++;
        end
        if (m_tdata[47:24] !== e.cy) begin
            $display("%0t: center_y expected %h actual %h", $time, e.cy, m_tdata[47:24]);
            errors++;
        end
        if (m_tdata[71:48] !== e.cz) begin
            $display("%0t: center_z expected %h actual %h", $time, e.cz, m_tdata[71:48]);
            errors++;
        end
        if (m_tdata[96:72] !== e.radius) begin
            $display("%0t: radius expected %h actual %h", $time, e.radius, m_tdata[96:72]);
            errors++;
        end
        if (m_tuser !== e.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time, e.overflow, m_tuser);
            errors++;
        end
    endtask

    initial begin
        errors = 0;
        spheres_due = 0;
        n_pts = 0;
        dropped = 1'b0;
        rad = 0;
        rad_sq = 0;
        for (int k = 0; k < 3; k++) ctr[k] = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) take_point();
            if (m_tvalid && m_tready) check_sphere();
            spheres_due = spheres_q.size();
        end
    end

endmodule

// File: tb/sv/ritter_bounding_sphere_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ritter_bounding_sphere_test
// Drives point sets into the bounding sphere block: directed corner, pair and tie sets, a
// long result back-pressure stretch, then random sets under several idle and
// stall mixes. The checker gives the error count.
// ----------------------------------------------------------------------------
module ritter_bounding_sphere_test;

    localparam int IDLE_LIMIT = 600000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;   // point_x, point_y, point_z
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // center_x, center_y, center_z, sphere_radius
    logic         m_tuser;   // overflow

    int errors;
    int spheres_due;
    int s_idle;
    int m_stall;
    int hold_len;
    int quiet;

    ritter_bounding_sphere dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ritter_bounding_sphere_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .spheres_due(spheres_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: random stalls, plus an occasional long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                hold_len--;
            end else begin
                m_tready <= ($urandom_range(99) >= m_stall);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                              input logic [23:0] z, input logic last);
        while ($urandom_range(99) < s_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [23:0] pick_coord(input int mode);
        case (mode)
            0: pick_coord = 24'($urandom);
            1: pick_coord = 24'($urandom_range(0, 15)) - 24'd8;
            2: begin
                case ($urandom_range(3))
                    0: pick_coord = 24'h7FFFFF;
                    1: pick_coord = 24'h800000;
                    2: pick_coord = 24'h000000;
                    default: pick_coord = 24'hFFFFFF;
                endcase
            end
            default: pick_coord = 24'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic send_set(input int n, input int mode);
        int m;
        for (int i = 0; i < n; i++) begin
            m = (mode < 0) ? $urandom_range(3) : mode;
            send_point(pick_coord(m), pick_coord(m), pick_coord(m), i == n - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (spheres_due != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_idle = 0;
        m_stall = 0;
        hold_len = 0;
        quiet = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner sets
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        send_point(24'h800000, 24'h800000, 24'h800000, 1'b1);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_point(24'h800000, 24'h800000, 24'h800000, 1'b1);
        send_point(24'h7FFFFF, 24'h800000, 24'h000000, 1'b0);
        send_point(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b1);
        // x and y pairs are the same points; the x pair wins the tie
        send_point(24'd5, 24'hFFFC18, 24'd0, 1'b0);
        send_point(24'd0, 24'd1000, 24'd0, 1'b0);
        send_point(24'd3, 24'd0, 24'd1, 1'b1);
        // y and z pairs are the same points; the y pair wins the tie
        send_point(24'd1, 24'd2, 24'hFFF000, 1'b0);
        send_point(24'd0, 24'd0, 24'd4096, 1'b0);
        send_point(24'd2, 24'd1, 24'd0, 1'b1);
        // ties everywhere
        send_point(24'd1, 24'd1, 24'd1, 1'b0);
        send_point(24'd1, 24'd1, 24'd1, 1'b0);
        send_point(24'd1, 24'd1, 24'd1, 1'b1);
        // far point off the initial pair grows the sphere
        send_point(24'hFFFF00, 24'd0, 24'd0, 1'b0);
        send_point(24'd256, 24'd0, 24'd0, 1'b0);
        send_point(24'd0, 24'd60000, 24'd0, 1'b0);
        send_point(24'd0, 24'd0, 24'hFF0000, 1'b1);
        drain();

        // long hold on the result side while sets keep coming
        hold_len = 3000;
        for (int i = 0; i < 3; i++) send_set(5, -1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin s_idle = 0;  m_stall = 0;  end
                1: begin s_idle = 52; m_stall = 0;  end
                2: begin s_idle = 0;  m_stall = 52; end
                default: begin s_idle = 8; m_stall = 8; end
            endcase
            for (int sent = 0; sent < 100; ) begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
                send_set(n, -1);
                sent += n;
            end
            drain();
        end

        s_idle = 0;
        m_stall = 0;
        repeat (100) @(posedge aclk);
        if (errors == 0 && spheres_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
